@@ rtl/core/assert_macros.svh @@
// Assertion macros used by the matcher RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMP(label, clk, rst_n, ante, cons)
`define ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

@@ rtl/core/bgm_pkg.sv @@
// Package for the boolean glob matcher: codes, character constants and helper functions.
`timescale 1ns / 1ps
`default_nettype none

package bgm_pkg;

  localparam int unsigned PATTERN_MAX_DEF = 32;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_AND   = 8'h26;
  localparam logic [7:0] CH_OR    = 8'h7C;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_TILDE = 8'h7E;
  localparam logic [7:0] CH_XOR   = 8'h5E;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_QMARK = 8'h3F;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;
  localparam logic [7:0] CH_DIGIT_0 = 8'h30;
  localparam logic [7:0] CH_DIGIT_9 = 8'h39;
  localparam logic [7:0] CASE_BIT = 8'h20;

  typedef enum logic [1:0] {
    KIND_APPEND = 2'd0,
    KIND_TEXT   = 2'd1,
    KIND_END    = 2'd2,
    KIND_CLEAR  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    FOLD_FIRST,
    FOLD_AND,
    FOLD_XOR,
    FOLD_OR
  } fold_t;

  // one-bit map, bit k holds f(k)
  typedef logic [1:0] bitfn_t;

  localparam bitfn_t FN_ID    = 2'b10;
  localparam bitfn_t FN_ZERO  = 2'b00;
  localparam bitfn_t FN_ONE   = 2'b11;
  localparam bitfn_t FN_INV   = 2'b01;

  function automatic logic is_op(input logic [7:0] c);
    return (c == CH_AND) || (c == CH_OR) || (c == CH_BANG) ||
           (c == CH_TILDE) || (c == CH_XOR);
  endfunction

  function automatic logic [7:0] fold_case(input logic [7:0] c);
    return ((c >= CH_UPPER_A) && (c <= CH_UPPER_Z)) ? (c | CASE_BIT) : c;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_DIGIT_0) && (c <= CH_DIGIT_9);
  endfunction

  function automatic fold_t op_fold(input logic [7:0] c);
    fold_t k;
    case (c)
      CH_AND:  k = FOLD_AND;
      CH_XOR:  k = FOLD_XOR;
      default: k = FOLD_OR;
    endcase
    return k;
  endfunction

  function automatic bitfn_t term_fn(input fold_t k, input logic t);
    bitfn_t f;
    unique case (k)
      FOLD_FIRST: f = t ? FN_ONE : FN_ZERO;
      FOLD_AND:   f = t ? FN_ID  : FN_ZERO;
      FOLD_XOR:   f = t ? FN_INV : FN_ID;
      FOLD_OR:    f = t ? FN_ONE : FN_ID;
      default:    f = FN_ID;
    endcase
    return f;
  endfunction

  // apply f first, then g
  function automatic bitfn_t compose(input bitfn_t f, input bitfn_t g);
    return {g[f[1]], g[f[0]]};
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/boolean_glob_matcher_unit.sv @@
// Boolean glob matcher: pattern store, bit-parallel NFA and term fold.
//
//  channel | ports                                  | dir | moves
//  in      | in_valid in_ready in_kind in_symbol    | in  | pattern, text, end, clear
//  out     | out_valid out_ready out_matched        | out | one result per end item
//          | out_pattern_overflow                   |     |
//
// One item per cycle unless the input is stalled; an item is taken into the input register
// and applied to the NFA state as it leaves it, one star closure add per text character.
// An end item's result is registered into the output register as it leaves the input register.
// Synchronous reset leaves an empty pattern and no pending result.
// Only an end item waiting for a full result register stalls the input.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module boolean_glob_matcher_unit #(
  parameter int unsigned PATTERN_MAX = bgm_pkg::PATTERN_MAX_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_kind,
  input  logic [7:0] in_symbol,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_matched,
  output logic       out_pattern_overflow
);
  import bgm_pkg::*;

  localparam int unsigned NPOS  = PATTERN_MAX + 1;
  localparam int unsigned LVL   = $clog2(NPOS);
  localparam int unsigned TSIZE = 1 << LVL;

  logic                   s1_valid_r;
  kind_t                  s1_kind_r;
  logic [7:0]             s1_sym_r;

  logic [7:0]             pchar_r [PATTERN_MAX];
  fold_t                  endk_r  [PATTERN_MAX];
  logic [PATTERN_MAX-1:0] star_r;
  logic [PATTERN_MAX-1:0] op_r;
  logic [PATTERN_MAX-1:0] qm_r;
  logic [PATTERN_MAX-1:0] hash_r;

  logic [PATTERN_MAX-1:0] valid_r;
  fold_t                  last_r;
  logic                   ovf_r;
  logic [NPOS-1:0]        start_r;
  logic [NPOS-1:0]        act_r;

  logic                   out_valid_r;
  logic                   out_matched_r;
  logic                   out_ovf_r;

  logic                   s1_go;
  logic                   sym_nz;
  logic                   full;
  logic                   do_write;
  logic [NPOS-1:0]        upto_len;
  logic [NPOS-1:0]        len_oh;
  logic                   start_at_len;
  logic                   new_bit;
  logic [NPOS-1:0]        start_app;
  logic [7:0]             tfold;
  logic                   tdigit;
  logic [PATTERN_MAX-1:0] hit;
  logic [PATTERN_MAX-1:0] stay;
  logic [NPOS-1:0]        raw;
  logic [NPOS-1:0]        prop;
  logic [NPOS-1:0]        gen;
  logic [NPOS-1:0]        sum;
  logic [NPOS-1:0]        closed;
  bitfn_t                 leaf [TSIZE];
  bitfn_t                 node [2*TSIZE];
  logic                   eval_match;

  // handshake
  assign s1_go    = s1_valid_r &&
                    ((s1_kind_r != KIND_END) || !out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_go;

  // pattern append
  assign sym_nz       = (s1_sym_r != CH_NUL);
  assign full         = valid_r[PATTERN_MAX-1];
  assign do_write     = s1_go && (s1_kind_r == KIND_APPEND) && sym_nz && !full;
  assign upto_len     = {valid_r, 1'b1};
  assign len_oh       = upto_len & ~{1'b0, valid_r};
  assign start_at_len = |(start_r & len_oh);
  assign new_bit      = is_op(s1_sym_r) || ((s1_sym_r == CH_STAR) && start_at_len);
  assign start_app    = start_r | ({len_oh[NPOS-2:0], 1'b0} & {NPOS{new_bit}});

  // NFA step
  assign tfold  = fold_case(s1_sym_r);
  assign tdigit = is_digit(s1_sym_r);

  always_comb begin
    for (int i = 0; i < PATTERN_MAX; i++) begin
      stay[i] = act_r[i] && valid_r[i] && star_r[i];
      hit[i]  = act_r[i] && valid_r[i] && !op_r[i] && !star_r[i] &&
                (qm_r[i] || (hash_r[i] && tdigit) ||
                 (!qm_r[i] && !hash_r[i] && (pchar_r[i] == tfold)));
    end
  end

  // star closure as a carry chain: stars propagate, active stars generate
  assign raw    = {hit, 1'b0} | {1'b0, stay};
  assign prop   = {1'b0, star_r & valid_r};
  assign gen    = raw & prop;
  assign sum    = prop + gen;
  assign closed = raw | (sum ^ prop ^ gen);

  // term fold as a tree of one-bit maps
  for (genvar i = 0; i < TSIZE; i++) begin : g_leaf
    if (i < PATTERN_MAX) begin : g_pat
      assign leaf[i] = len_oh[i] ? term_fn(last_r, act_r[i]) :
                       ((valid_r[i] && op_r[i]) ? term_fn(endk_r[i], act_r[i]) : FN_ID);
    end else if (i < NPOS) begin : g_tail
      assign leaf[i] = len_oh[i] ? term_fn(last_r, act_r[i]) : FN_ID;
    end else begin : g_pad
      assign leaf[i] = FN_ID;
    end
  end

  always_comb begin
    node[0] = FN_ID;
    for (int i = 0; i < TSIZE; i++) begin
      node[TSIZE+i] = leaf[i];
    end
    for (int n = TSIZE - 1; n >= 1; n--) begin
      node[n] = compose(node[2*n], node[2*n+1]);
    end
  end

  assign eval_match = node[1][0];

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      valid_r     <= '0;
      last_r      <= FOLD_FIRST;
      ovf_r       <= 1'b0;
      start_r     <= NPOS'(1);
      act_r       <= NPOS'(1);
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (s1_go && (s1_kind_r == KIND_END)) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (s1_go) begin
        unique case (s1_kind_r)
          KIND_APPEND: begin
            if (sym_nz) begin
              if (full) begin
                ovf_r <= 1'b1;
                act_r <= start_r;
              end else begin
                valid_r <= {valid_r[PATTERN_MAX-2:0], 1'b1};
                start_r <= start_app;
                act_r   <= start_app;
                if (is_op(s1_sym_r)) begin
                  last_r <= op_fold(s1_sym_r);
                end
              end
            end
          end
          KIND_TEXT: begin
            if (sym_nz) begin
              act_r <= closed;
            end
          end
          KIND_END: begin
            act_r <= start_r;
          end
          KIND_CLEAR: begin
            valid_r <= '0;
            ovf_r   <= 1'b0;
            last_r  <= FOLD_FIRST;
            start_r <= NPOS'(1);
            act_r   <= NPOS'(1);
          end
          default: begin
            act_r <= start_r;
          end
        endcase
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_kind_r <= kind_t'(in_kind);
      s1_sym_r  <= in_symbol;
    end
    if (s1_go && (s1_kind_r == KIND_END)) begin
      out_matched_r <= eval_match;
      out_ovf_r     <= ovf_r;
    end
    for (int i = 0; i < PATTERN_MAX; i++) begin
      if (do_write && len_oh[i]) begin
        pchar_r[i] <= fold_case(s1_sym_r);
        endk_r[i]  <= last_r;
        star_r[i]  <= (s1_sym_r == CH_STAR);
        op_r[i]    <= is_op(s1_sym_r);
        qm_r[i]    <= (s1_sym_r == CH_QMARK);
        hash_r[i]  <= (s1_sym_r == CH_HASH);
      end
    end
  end

  assign out_valid            = out_valid_r;
  assign out_matched          = out_matched_r;
  assign out_pattern_overflow = out_ovf_r;

  `ASSERT_IMP(a_len_thermo, clk, rst_n, 1'b1, (valid_r & (valid_r + 1'b1)) == '0)
  `ASSERT_IMP(a_act_in_range, clk, rst_n, 1'b1, (act_r & ~upto_len) == '0)
  `ASSERT_IMP(a_start_in_range, clk, rst_n, 1'b1, start_r[0] && ((start_r & ~upto_len) == '0))
  `ASSERT_NXT(a_out_from_end, clk, rst_n, !out_valid_r && !(s1_go && (s1_kind_r == KIND_END)), !out_valid_r)

endmodule

`default_nettype wire

@@ verif/boolean_glob_matcher_unit_test.sv @@
// Testbench for the boolean glob matcher: directed table, random queries, result scoreboard.
`timescale 1ns / 1ps

module boolean_glob_matcher_unit_test;
  import bgm_pkg::*;

  localparam int unsigned PATTERN_MAX = PATTERN_MAX_DEF;
  localparam int unsigned RANDOM_ITEMS = 1650;
  localparam longint unsigned CYCLE_LIMIT = 1000000;

  typedef struct packed {
    logic matched;
    logic overflow;
  } verdict_t;

  typedef struct packed {
    kind_t kind;
    logic [7:0] sym;
    logic pinned;
    verdict_t want;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] in_kind = KIND_APPEND;
  logic [7:0] in_symbol = 8'h00;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_matched;
  logic out_pattern_overflow;

  logic [7:0] pat_chars [PATTERN_MAX];
  int unsigned pat_len = 0;
  logic pat_dropped = 1'b0;
  logic [PATTERN_MAX:0] live_pos = (PATTERN_MAX + 1)'(1);

  verdict_t expected_verdicts [$];
  int unsigned mismatches = 0;
  int unsigned accepted_items = 0;
  longint unsigned cycles = 0;
  bit calm_phase = 1'b0;

  // pinned rows carry a hand-written expectation
  row_t script [0:27] = '{
    '{KIND_END,    CH_NUL,   1'b1, 2'b10},
    '{KIND_TEXT,   "a",      1'b0, 2'b00},
    '{KIND_END,    8'hFF,    1'b1, 2'b00},
    '{KIND_APPEND, CH_NUL,   1'b0, 2'b00},
    '{KIND_APPEND, "A",      1'b0, 2'b00},
    '{KIND_APPEND, CH_STAR,  1'b0, 2'b00},
    '{KIND_APPEND, CH_HASH,  1'b0, 2'b00},
    '{KIND_APPEND, CH_AND,   1'b0, 2'b00},
    '{KIND_APPEND, CH_QMARK, 1'b0, 2'b00},
    '{KIND_APPEND, CH_STAR,  1'b0, 2'b00},
    '{KIND_TEXT,   "a",      1'b0, 2'b00},
    '{KIND_TEXT,   CH_NUL,   1'b0, 2'b00},
    '{KIND_TEXT,   "Z",      1'b0, 2'b00},
    '{KIND_TEXT,   "7",      1'b0, 2'b00},
    '{KIND_END,    8'h00,    1'b0, 2'b00},
    '{KIND_APPEND, CH_XOR,   1'b0, 2'b00},
    '{KIND_APPEND, 8'hFF,    1'b0, 2'b00},
    '{KIND_APPEND, CH_OR,    1'b0, 2'b00},
    '{KIND_APPEND, CH_BANG,  1'b0, 2'b00},
    '{KIND_APPEND, CH_TILDE, 1'b0, 2'b00},
    '{KIND_TEXT,   "a",      1'b0, 2'b00},
    '{KIND_APPEND, "b",      1'b0, 2'b00},
    '{KIND_TEXT,   8'hFF,    1'b0, 2'b00},
    '{KIND_END,    8'h55,    1'b0, 2'b00},
    '{KIND_CLEAR,  8'h5A,    1'b0, 2'b00},
    '{KIND_TEXT,   8'h80,    1'b0, 2'b00},
    '{KIND_END,    8'hAA,    1'b1, 2'b00},
    '{KIND_END,    8'h00,    1'b1, 2'b10}
  };

  boolean_glob_matcher_unit #(
    .PATTERN_MAX(PATTERN_MAX)
  ) i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_kind(in_kind),
    .in_symbol(in_symbol),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_matched(out_matched),
    .out_pattern_overflow(out_pattern_overflow)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic is_split(input logic [7:0] c);
    return (c == CH_AND) || (c == CH_OR) || (c == CH_BANG) || (c == CH_TILDE) ||
           (c == CH_XOR);
  endfunction

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    return (c >= "A" && c <= "Z") ? 8'(c + 8'd32) : c;
  endfunction

  function automatic logic [PATTERN_MAX:0] with_stars(input logic [PATTERN_MAX:0] v);
    for (int i = 0; i < pat_len; i++) begin
      if (v[i] && pat_chars[i] == CH_STAR) v[i + 1] = 1'b1;
    end
    return v;
  endfunction

  function automatic void rearm();
    live_pos = '0;
    live_pos[0] = 1'b1;
    for (int i = 0; i < pat_len; i++) begin
      if (is_split(pat_chars[i])) live_pos[i + 1] = 1'b1;
    end
    live_pos = with_stars(live_pos);
  endfunction

  function automatic bit predict_verdict(input kind_t k, input logic [7:0] s,
                                         output verdict_t v);
    logic [PATTERN_MAX:0] nxt;
    logic acc;
    logic [7:0] pend;
    bit first;
    v = '0;
    case (k)
      KIND_APPEND: begin
        if (s == CH_NUL) return 1'b0;
        if (pat_len < PATTERN_MAX) begin
          pat_chars[pat_len] = s;
          pat_len++;
        end else begin
          pat_dropped = 1'b1;
        end
        rearm();
      end
      KIND_TEXT: begin
        if (s != CH_NUL) begin
          nxt = '0;
          for (int i = 0; i < pat_len; i++) begin
            if (live_pos[i] && !is_split(pat_chars[i])) begin
              if (pat_chars[i] == CH_STAR) nxt[i] = 1'b1;
              else if (pat_chars[i] == CH_QMARK) nxt[i + 1] = 1'b1;
              else if (pat_chars[i] == CH_HASH) begin
                if (s >= CH_DIGIT_0 && s <= CH_DIGIT_9) nxt[i + 1] = 1'b1;
              end else if (to_lower(pat_chars[i]) == to_lower(s)) nxt[i + 1] = 1'b1;
            end
          end
          live_pos = with_stars(nxt);
        end
      end
      KIND_END: begin
        acc = 1'b0;
        pend = CH_NUL;
        first = 1'b1;
        for (int i = 0; i <= pat_len; i++) begin
          if (i == pat_len || is_split(pat_chars[i])) begin
            if (first) acc = live_pos[i];
            else if (pend == CH_AND) acc = acc & live_pos[i];
            else if (pend == CH_XOR) acc = acc ^ live_pos[i];
            else acc = acc | live_pos[i];
            first = 1'b0;
            if (i < pat_len) pend = pat_chars[i];
          end
        end
        v.matched = acc;
        v.overflow = pat_dropped;
        rearm();
        return 1'b1;
      end
      default: begin
        pat_len = 0;
        pat_dropped = 1'b0;
        rearm();
      end
    endcase
    return 1'b0;
  endfunction

  function automatic int unsigned burst_len();
    return ($urandom_range(0, 99) < 80) ? $urandom_range(1, 3) : $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] rand_letter();
    return 8'(($urandom_range(0, 1) ? 8'h41 : 8'h61) + $urandom_range(0, 25));
  endfunction

  function automatic logic [7:0] rand_text_char();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return rand_letter();
    if (r < 75) return 8'(CH_DIGIT_0 + $urandom_range(0, 9));
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] rand_pattern_char();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 40) return rand_letter();
    if (r < 55) return CH_STAR;
    if (r < 63) return CH_QMARK;
    if (r < 71) return CH_HASH;
    if (r < 81) begin
      case ($urandom_range(0, 4))
        0: return CH_AND;
        1: return CH_OR;
        2: return CH_BANG;
        3: return CH_TILDE;
        default: return CH_XOR;
      endcase
    end
    if (r < 91) return 8'(CH_DIGIT_0 + $urandom_range(0, 9));
    return 8'($urandom_range(1, 255));
  endfunction

  task automatic send_item(input kind_t k, input logic [7:0] s, input logic pinned,
                           input verdict_t pinned_v);
    verdict_t v;
    in_valid <= 1'b1;
    in_kind <= k;
    in_symbol <= s;
    do @(posedge clk); while (!in_ready);
    accepted_items++;
    if (predict_verdict(k, s, v)) expected_verdicts.push_back(pinned ? pinned_v : v);
    if (!calm_phase && $urandom_range(0, 99) >= 60) begin
      in_valid <= 1'b0;
      repeat (burst_len()) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_verdicts.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if (rst_n && !calm_phase && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat (burst_len()) @(posedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    verdict_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_verdicts.size() == 0) begin
        $error("unexpected result: matched=%0b pattern_overflow=%0b", out_matched,
               out_pattern_overflow);
        mismatches++;
      end else begin
        want = expected_verdicts.pop_front();
        if (out_matched !== want.matched) begin
          $error("matched: expected %0b, got %0b", want.matched, out_matched);
          mismatches++;
        end
        if (out_pattern_overflow !== want.overflow) begin
          $error("pattern_overflow: expected %0b, got %0b", want.overflow,
                 out_pattern_overflow);
          mismatches++;
        end
      end
    end
  end

  initial begin
    int unsigned queries;
    int unsigned n_terms;
    int unsigned pick;
    int unsigned term;
    int unsigned target;
    logic [7:0] c;
    logic [7:0] txt [$];
    queries = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    foreach (script[r]) send_item(script[r].kind, script[r].sym, script[r].pinned,
                                  script[r].want);
    drain_results();
    target = accepted_items + RANDOM_ITEMS;
    while (accepted_items < target) begin
      queries++;
      calm_phase = ($urandom_range(0, 5) == 0);
      if (queries % 40 == 0) drain_results();
      if ($urandom_range(0, 99) < 20) begin
        send_item(KIND_CLEAR, 8'($urandom_range(0, 255)), 1'b0, '0);
        repeat (($urandom_range(0, 4) == 0) ? $urandom_range(30, 40) : $urandom_range(1, 8))
          send_item(KIND_APPEND, rand_pattern_char(), 1'b0, '0);
      end else if ($urandom_range(0, 99) < 12) begin
        repeat ($urandom_range(1, 2)) send_item(KIND_APPEND, rand_pattern_char(), 1'b0, '0);
      end
      txt.delete();
      if ($urandom_range(0, 3) != 0) begin
        n_terms = 1;
        for (int i = 0; i < pat_len; i++) if (is_split(pat_chars[i])) n_terms++;
        pick = $urandom_range(0, n_terms - 1);
        term = 0;
        for (int i = 0; i < pat_len; i++) begin
          c = pat_chars[i];
          if (is_split(c)) term++;
          else if (term == pick) begin
            if (c == CH_STAR) repeat ($urandom_range(0, 2)) txt.push_back(rand_text_char());
            else if (c == CH_QMARK) txt.push_back(8'($urandom_range(1, 255)));
            else if (c == CH_HASH) txt.push_back(8'(CH_DIGIT_0 + $urandom_range(0, 9)));
            else if ((c | CASE_BIT) >= "a" && (c | CASE_BIT) <= "z")
              txt.push_back($urandom_range(0, 1) ? (c | CASE_BIT) : (c & ~CASE_BIT));
            else txt.push_back(c);
          end
        end
      end else begin
        repeat ($urandom_range(0, 6)) txt.push_back(rand_text_char());
      end
      foreach (txt[i]) begin
        if ($urandom_range(0, 49) == 0)
          send_item(kind_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)), 1'b0, '0);
        send_item(KIND_TEXT, txt[i], 1'b0, '0);
      end
      send_item(KIND_END, 8'($urandom_range(0, 255)), 1'b0, '0);
    end
    drain_results();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
